// File: rtl/i2c_master_bit_sequencer_unit_defines.svh
// assertion macros for the i2c master bit sequencer
// used by modules that include this header, expects clk and rst in scope
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define I2CMBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2cmbs_pkg.sv
// shared types, codes and small tables for the i2c master bit sequencer
// no dependencies
`default_nettype none

package i2cmbs_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_t;

  localparam logic [15:0] STEP_TICKS_RESET = 16'd720;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
    logic       ack_value;
    logic       sda_in;
  } item_t;

  // idx mod 3 and (idx div 3) mod 8 for a 5 bit step index
  localparam logic [1:0] MOD3 [32] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
  };

  localparam logic [2:0] DIV3 [32] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7,
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2
  };

  function automatic logic [4:0] run_length(op_t op);
    logic [4:0] len;
    case (op)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd25;
      OP_SACK:  len = 5'd3;
      OP_RACK:  len = 5'd4;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/i2cmbs_ifs.sv
// valid/ready channel interfaces for the i2c master bit sequencer
// no dependencies
`default_nettype none

interface i2cmbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;
  logic       ack_value;
  logic       sda_in;
  modport source (output valid, operation, data_byte, ack_value, sda_in, input ready);
  modport sink (input valid, operation, data_byte, ack_value, sda_in, output ready);
endinterface

interface i2cmbs_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] received_byte;
  logic       received_ack;
  logic       status;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, received_byte,
                  received_ack, status, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, received_byte,
                received_ack, status, output ready);
endinterface

interface i2cmbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/i2cmbs_in_stage.sv
// input register for the i2c master bit sequencer
// depends on i2cmbs_pkg and i2cmbs_in_if
`default_nettype none

module i2cmbs_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  i2cmbs_in_if.sink              in_ch,
  input  wire logic              take,
  output i2cmbs_pkg::item_t      item,
  output logic                   item_valid
);

  assign in_ch.ready = !rst && (!item_valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.operation <= i2cmbs_pkg::op_t'(in_ch.operation);
      item.data_byte <= in_ch.data_byte;
      item.ack_value <= in_ch.ack_value;
      item.sda_in    <= in_ch.sda_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2cmbs_seq.sv
// sequencer state, line update logic and result register
// depends on i2cmbs_pkg, i2cmbs_out_if and the defines header
`default_nettype none
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2cmbs_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire i2cmbs_pkg::item_t item,
  input  wire logic              item_valid,
  input  wire logic [15:0]       step_ticks,
  output logic                   take,
  i2cmbs_out_if.source           out_ch
);

  i2cmbs_pkg::op_t active;
  logic [4:0]      step_index;
  logic [15:0]     hold_count;
  logic [7:0]      shift_byte;
  logic            scl_level;
  logic            sda_level;
  logic            ack_latch;
  logic [7:0]      rx_hold;
  logic            done;
  logic            status;
  logic            res_valid;

  i2cmbs_pkg::op_t active_next;
  logic [4:0]      step_index_next;
  logic [15:0]     hold_count_next;
  logic [7:0]      shift_byte_next;
  logic            scl_level_next;
  logic            sda_level_next;
  logic            ack_latch_next;
  logic [7:0]      rx_hold_next;
  logic            done_next;
  logic            status_next;

  logic [15:0] hold_len;
  logic        busy;
  logic        act;
  logic [4:0]  act_idx;
  logic [4:0]  idx_inc;
  logic [1:0]  read_phase;

  assign take     = item_valid && (!res_valid || out_ch.ready);
  assign hold_len = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
  assign busy     = active != i2cmbs_pkg::OP_TICK;
  assign idx_inc  = step_index + 5'd1;

  always_comb begin
    active_next     = active;
    step_index_next = step_index;
    hold_count_next = hold_count;
    shift_byte_next = shift_byte;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;
    ack_latch_next  = ack_latch;
    rx_hold_next    = rx_hold;
    done_next       = 1'b0;
    status_next     = 1'b0;
    act             = 1'b0;
    act_idx         = 5'd0;
    read_phase      = 2'd0;

    case (item.operation)
      i2cmbs_pkg::OP_TICK: begin
        if (busy) begin
          if (hold_count > 16'd1) begin
            hold_count_next = hold_count - 16'd1;
          end else if (idx_inc >= i2cmbs_pkg::run_length(active)) begin
            if (active == i2cmbs_pkg::OP_READ) begin
              rx_hold_next = shift_byte;
            end
            active_next     = i2cmbs_pkg::OP_TICK;
            step_index_next = 5'd0;
            hold_count_next = 16'd0;
            done_next       = 1'b1;
          end else begin
            act             = 1'b1;
            act_idx         = idx_inc;
            step_index_next = idx_inc;
            hold_count_next = hold_len;
          end
        end
      end
      i2cmbs_pkg::OP_START, i2cmbs_pkg::OP_STOP, i2cmbs_pkg::OP_WRITE,
      i2cmbs_pkg::OP_READ, i2cmbs_pkg::OP_SACK, i2cmbs_pkg::OP_RACK: begin
        if (busy) begin
          status_next = 1'b1;
        end else begin
          active_next     = item.operation;
          step_index_next = 5'd0;
          hold_count_next = hold_len;
          act             = 1'b1;
          if (item.operation == i2cmbs_pkg::OP_WRITE) begin
            shift_byte_next = item.data_byte;
          end else if (item.operation == i2cmbs_pkg::OP_READ) begin
            shift_byte_next = 8'd0;
          end
        end
      end
      default: begin
      end
    endcase

    if (act) begin
      read_phase = i2cmbs_pkg::MOD3[act_idx - 5'd1];
      case (active_next)
        i2cmbs_pkg::OP_START: begin
          if (act_idx == 5'd0) sda_level_next = 1'b1;
          else if (act_idx == 5'd1) scl_level_next = 1'b1;
          else if (act_idx == 5'd2) sda_level_next = 1'b0;
          else scl_level_next = 1'b0;
        end
        i2cmbs_pkg::OP_STOP: begin
          if (act_idx == 5'd0) sda_level_next = 1'b0;
          else if (act_idx == 5'd1) scl_level_next = 1'b1;
          else sda_level_next = 1'b1;
        end
        i2cmbs_pkg::OP_WRITE: begin
          if (i2cmbs_pkg::MOD3[act_idx] == 2'd0) begin
            sda_level_next = shift_byte_next[~i2cmbs_pkg::DIV3[act_idx]];
          end else if (i2cmbs_pkg::MOD3[act_idx] == 2'd1) begin
            scl_level_next = 1'b1;
          end else begin
            scl_level_next = 1'b0;
          end
        end
        i2cmbs_pkg::OP_READ: begin
          if (act_idx == 5'd0) sda_level_next = 1'b1;
          else if (read_phase == 2'd0) scl_level_next = 1'b1;
          else if (read_phase == 2'd1) shift_byte_next = {shift_byte[6:0], item.sda_in};
          else scl_level_next = 1'b0;
        end
        i2cmbs_pkg::OP_SACK: begin
          if (act_idx == 5'd0) sda_level_next = item.ack_value;
          else if (act_idx == 5'd1) scl_level_next = 1'b1;
          else scl_level_next = 1'b0;
        end
        i2cmbs_pkg::OP_RACK: begin
          if (act_idx == 5'd0) sda_level_next = 1'b1;
          else if (act_idx == 5'd1) scl_level_next = 1'b1;
          else if (act_idx == 5'd2) ack_latch_next = item.sda_in;
          else scl_level_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= i2cmbs_pkg::OP_TICK;
      step_index <= 5'd0;
      hold_count <= 16'd0;
      shift_byte <= 8'd0;
      scl_level  <= 1'b1;
      sda_level  <= 1'b1;
      ack_latch  <= 1'b1;
      rx_hold    <= 8'd0;
      res_valid  <= 1'b0;
    end else begin
      if (take) begin
        active     <= active_next;
        step_index <= step_index_next;
        hold_count <= hold_count_next;
        shift_byte <= shift_byte_next;
        scl_level  <= scl_level_next;
        sda_level  <= sda_level_next;
        ack_latch  <= ack_latch_next;
        rx_hold    <= rx_hold_next;
        res_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      done   <= done_next;
      status <= status_next;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.scl_out       = scl_level;
  assign out_ch.sda_out       = sda_level;
  assign out_ch.busy_res      = busy;
  assign out_ch.done_res      = done;
  assign out_ch.received_byte = rx_hold;
  assign out_ch.received_ack  = ack_latch;
  assign out_ch.status        = status;

  `I2CMBS_ASSERT_NOW(a_idle_clear, !busy, step_index == 5'd0 && hold_count == 16'd0, "idle with step state left")
  `I2CMBS_ASSERT_NEXT(a_done_idle, take && done_next, !busy && done, "finished command still busy")
  `I2CMBS_ASSERT_NEXT(a_reject_keeps, take && status_next, active == $past(active) && $stable(step_index), "rejected command changed the run")
  `I2CMBS_ASSERT_NOW(a_busy_hold, busy, hold_count != 16'd0, "active run with empty hold count")

endmodule

`default_nettype wire

// File: rtl/i2c_master_bit_sequencer_unit.sv
// top level of the i2c master bit sequencer: step length register and channel wiring
// depends on i2cmbs_pkg, i2cmbs_ifs, i2cmbs_in_stage and i2cmbs_seq
//
// in_ch carries one item per handshake: a tick (operation 0, with the sampled sda level)
// or a command (start, stop, write byte, read byte, send ack, read ack).
// out_ch returns exactly one result item per input item: the scl and sda drive levels,
// busy, done, the last received byte and ack, and a status bit set when a command
// arrived while a run was still active.
// cfg_ch writes step_ticks, the number of ticks each line update is held; it is ready
// whenever reset is low and must only be written while the block is idle. reset value
// is 720.
// an item is registered on entry and its result is registered again in the sequencer's result register.
// throughput: one item per cycle while out_ch does not stall; the sequencer updates its state as each item is taken.
// when out_ch stalls, the result register holds and the input register fills, after
// which in_ch ready drops; no item is lost or repeated.
// reset (rst, synchronous) leaves the lines released, the block idle and both
// registers empty; no channel is ready while reset is high.
`default_nettype none

module i2c_master_bit_sequencer_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  i2cmbs_in_if.sink     in_ch,
  i2cmbs_out_if.source  out_ch,
  i2cmbs_cfg_if.sink    cfg_ch
);

  logic [15:0]       step_ticks;
  i2cmbs_pkg::item_t item;
  logic              item_valid;
  logic              take;

  assign cfg_ch.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks <= i2cmbs_pkg::STEP_TICKS_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      step_ticks <= cfg_ch.data;
    end
  end

  i2cmbs_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  i2cmbs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .step_ticks (step_ticks),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/i2cmbs_tb_pkg.sv
// stimulus and result types plus the line-level scoreboard for the i2c bit sequencer bench
// depends on i2cmbs_pkg for the operation codes and the step length reset value
package i2cmbs_tb_pkg;
  import i2cmbs_pkg::*;

  localparam logic [2:0] OP_NONE  = 3'd7;
  localparam logic [2:0] CMD_IDLE = 3'd0;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       ackv;
    logic       sda;
  } stim_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       rx_ack;
    logic       status;
  } line_result_t;

  class line_scoreboard;
    logic [15:0]  step_ticks;
    logic [2:0]   cmd;
    logic [4:0]   idx;
    logic [15:0]  hold;
    logic [7:0]   shift;
    logic [7:0]   rx_byte;
    logic         scl;
    logic         sda;
    logic         ack;
    line_result_t expected_q[$];
    int           mismatches;
    int           checked;

    function new();
      step_ticks = STEP_TICKS_RESET;
      cmd        = CMD_IDLE;
      idx        = '0;
      hold       = '0;
      shift      = '0;
      rx_byte    = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      ack        = 1'b1;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_step(logic [15:0] val);
      step_ticks = val;
    endfunction

    function bit busy();
      return cmd != CMD_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [15:0] hold_ticks();
      return (step_ticks == 16'd0) ? 16'd1 : step_ticks;
    endfunction

    function logic [4:0] run_steps(logic [2:0] op);
      case (op)
        OP_START: return 5'd4;
        OP_STOP:  return 5'd3;
        OP_WRITE: return 5'd24;
        OP_READ:  return 5'd25;
        OP_SACK:  return 5'd3;
        OP_RACK:  return 5'd4;
        default:  return 5'd0;
      endcase
    endfunction

    function void apply_step(logic [4:0] n, logic sda_in, logic ackv);
      int bit_pos;
      int phase;
      bit_pos = (int'(n) / 3) % 8;
      phase   = int'(n) % 3;
      case (cmd)
        OP_START: begin
          if (n == 5'd0) sda = 1'b1;
          else if (n == 5'd1) scl = 1'b1;
          else if (n == 5'd2) sda = 1'b0;
          else scl = 1'b0;
        end
        OP_STOP: begin
          if (n == 5'd0) sda = 1'b0;
          else if (n == 5'd1) scl = 1'b1;
          else sda = 1'b1;
        end
        OP_WRITE: begin
          if (phase == 0) sda = shift[7 - bit_pos];
          else if (phase == 1) scl = 1'b1;
          else scl = 1'b0;
        end
        OP_READ: begin
          if (n == 5'd0) begin
            sda = 1'b1;
          end else begin
            phase = (int'(n) - 1) % 3;
            if (phase == 0) scl = 1'b1;
            else if (phase == 1) shift = {shift[6:0], sda_in};
            else scl = 1'b0;
          end
        end
        OP_SACK: begin
          if (n == 5'd0) sda = ackv;
          else if (n == 5'd1) scl = 1'b1;
          else scl = 1'b0;
        end
        OP_RACK: begin
          if (n == 5'd0) sda = 1'b1;
          else if (n == 5'd1) scl = 1'b1;
          else if (n == 5'd2) ack = sda_in;
          else scl = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void note_input(stim_t s);
      line_result_t r;
      r = '0;
      if (s.op == OP_TICK) begin
        if (cmd != CMD_IDLE) begin
          if (hold > 16'd1) begin
            hold = hold - 16'd1;
          end else begin
            idx = idx + 5'd1;
            if (idx >= run_steps(cmd)) begin
              if (cmd == OP_READ) rx_byte = shift;
              cmd    = CMD_IDLE;
              idx    = '0;
              hold   = '0;
              r.done = 1'b1;
            end else begin
              apply_step(idx, s.sda, 1'b0);
              hold = hold_ticks();
            end
          end
        end
      end else if (s.op != OP_NONE) begin
        if (cmd != CMD_IDLE) begin
          r.status = 1'b1;
        end else begin
          cmd = s.op;
          idx = '0;
          if (s.op == OP_WRITE) shift = s.data;
          else if (s.op == OP_READ) shift = '0;
          apply_step(5'd0, s.sda, s.ackv);
          hold = hold_ticks();
        end
      end
      r.scl     = scl;
      r.sda     = sda;
      r.busy    = (cmd != CMD_IDLE);
      r.rx_byte = rx_byte;
      r.rx_ack  = ack;
      expected_q.push_back(r);
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch at result %0d, %s: expected %0h, got %0h", checked, what, want, got);
    endfunction

    function void check_result(line_result_t got);
      line_result_t want;
      if (expected_q.size() == 0) begin
        flag("result with nothing expected", 0, int'(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.scl !== want.scl) flag("scl_out", want.scl, got.scl);
      if (got.sda !== want.sda) flag("sda_out", want.sda, got.sda);
      if (got.busy !== want.busy) flag("busy_res", want.busy, got.busy);
      if (got.done !== want.done) flag("done_res", want.done, got.done);
      if (got.rx_byte !== want.rx_byte) flag("received_byte", want.rx_byte, got.rx_byte);
      if (got.rx_ack !== want.rx_ack) flag("received_ack", want.rx_ack, got.rx_ack);
      if (got.status !== want.status) flag("status", want.status, got.status);
      checked++;
    endfunction

    function void close();
      if (expected_q.size() != 0) flag("results never arrived", expected_q.size(), 0);
    endfunction
  endclass

endpackage

// File: tb/tb_i2c_master_bit_sequencer_unit.sv
// top-level bench for the i2c master bit sequencer: drives ticks and commands with random
// idling on both channels and checks every result item against the line scoreboard
// depends on i2cmbs_pkg, i2cmbs_ifs, i2cmbs_tb_pkg and i2c_master_bit_sequencer_unit
module tb_i2c_master_bit_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmbs_pkg::*;
  import i2cmbs_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PAUSE_EVERY = 150;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;
  logic [2:0] next_cmd;

  line_scoreboard sb = new();

  i2cmbs_in_if  in_ch();
  i2cmbs_out_if out_ch();
  i2cmbs_cfg_if cfg_ch();

  i2c_master_bit_sequencer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.scl     = out_ch.scl_out;
      got.sda     = out_ch.sda_out;
      got.busy    = out_ch.busy_res;
      got.done    = out_ch.done_res;
      got.rx_byte = out_ch.received_byte;
      got.rx_ack  = out_ch.received_ack;
      got.status  = out_ch.status;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic stim_t mk(logic [2:0] op, logic [7:0] data, logic ackv, logic sda);
    stim_t s;
    s.op   = op;
    s.data = data;
    s.ackv = ackv;
    s.sda  = sda;
    return s;
  endfunction

  task automatic send_item(input stim_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= s.op;
    in_ch.data_byte <= s.data;
    in_ch.ack_value <= s.ackv;
    in_ch.sda_in    <= s.sda;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(s);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_step(input logic [15:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_step(val);
    cfg_ch.valid <= 1'b0;
  endtask

  // sda_mode 0 or 1 holds sda at that level, anything else randomizes it
  task automatic run_to_idle(input int sda_mode);
    logic sda;
    while (sb.busy()) begin
      sda = (sda_mode == 0 || sda_mode == 1) ? 1'(sda_mode) : 1'($urandom_range(1));
      send_item(mk(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), sda));
    end
  endtask

  // follows a plausible transfer order most of the time
  function automatic logic [2:0] pick_command();
    logic [2:0] op;
    if ($urandom_range(99) < 80) op = next_cmd;
    else op = 3'($urandom_range(6, 1));
    case (op)
      OP_START: next_cmd = OP_WRITE;
      OP_WRITE: next_cmd = OP_RACK;
      OP_RACK: begin
        case ($urandom_range(2))
          0:       next_cmd = OP_WRITE;
          1:       next_cmd = OP_READ;
          default: next_cmd = OP_STOP;
        endcase
      end
      OP_READ:  next_cmd = OP_SACK;
      OP_SACK:  next_cmd = $urandom_range(1) ? OP_READ : OP_STOP;
      default:  next_cmd = OP_START;
    endcase
    return op;
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    int r;
    s.data = 8'($urandom_range(255));
    s.ackv = 1'($urandom_range(1));
    s.sda  = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (sb.busy()) begin
      if (r < 90) s.op = OP_TICK;
      else if (r < 96) s.op = 3'($urandom_range(6, 1));
      else s.op = OP_NONE;
    end else begin
      if (r < 75) s.op = pick_command();
      else if (r < 88) s.op = OP_TICK;
      else s.op = OP_NONE;
    end
    return s;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % PAUSE_EVERY == PAUSE_EVERY - 1) wait_drained();
      send_item(random_item());
    end
  endtask

  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.data_byte <= '0;
    in_ch.ack_value <= 1'b0;
    in_ch.sda_in    <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    stall_cycles    <= 0;
    next_cmd        = OP_START;
    send_idle_pct   = 22;
    recv_idle_pct   = 63;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset step length, idle tick, unused code, rejected commands
    send_item(mk(OP_TICK, 8'h00, 1'b0, 1'b0));
    send_item(mk(OP_NONE, 8'hFF, 1'b1, 1'b1));
    send_item(mk(OP_START, 8'h00, 1'b0, 1'b0));
    send_item(mk(OP_WRITE, 8'h5A, 1'b1, 1'b1));
    send_item(mk(OP_NONE, 8'h00, 1'b0, 1'b0));
    run_to_idle(2);

    // zero step length, every command at least once, with a stop rejected behind a write
    write_step(16'd0);
    send_item(mk(OP_WRITE, 8'hFF, 1'b0, 1'b0));
    run_to_idle(2);
    send_item(mk(OP_WRITE, 8'h00, 1'b1, 1'b1));
    run_to_idle(2);
    send_item(mk(OP_WRITE, 8'hA5, 1'b0, 1'b1));
    send_item(mk(OP_STOP, 8'h00, 1'b0, 1'b0));
    run_to_idle(2);
    send_item(mk(OP_READ, 8'h3C, 1'b1, 1'b0));
    run_to_idle(1);
    send_item(mk(OP_READ, 8'hC3, 1'b0, 1'b1));
    run_to_idle(0);
    send_item(mk(OP_SACK, 8'h00, 1'b0, 1'b1));
    run_to_idle(2);
    send_item(mk(OP_SACK, 8'hFF, 1'b1, 1'b0));
    run_to_idle(2);
    send_item(mk(OP_RACK, 8'h00, 1'b0, 1'b1));
    run_to_idle(0);
    send_item(mk(OP_RACK, 8'h00, 1'b1, 1'b0));
    run_to_idle(1);
    send_item(mk(OP_START, 8'h00, 1'b0, 1'b0));
    run_to_idle(2);
    send_item(mk(OP_STOP, 8'h00, 1'b0, 1'b0));
    run_to_idle(2);

    write_step(16'd1);
    random_phase(450);
    run_to_idle(2);

    send_idle_pct = 63;
    recv_idle_pct = 22;
    write_step(16'd2);
    random_phase(400);
    run_to_idle(2);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_step(16'($urandom_range(5, 3)));
    random_phase(300);
    run_to_idle(2);

    // longest hold, left busy to the end
    write_step(16'hFFFF);
    send_item(mk(OP_START, 8'h00, 1'b0, 1'b0));
    random_phase(60);

    wait_drained();
    repeat (20) @(posedge clk);
    sb.close();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
